@@ sv/sfd_pkg.sv @@
`default_nettype none

package sfd_pkg;

    localparam int SFD_BUFFER_BYTES = 684;
    localparam int IDX_W = 10;
    localparam int LEN_W = 10;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam int RLE_FLAG_BIT = 0;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SUM_BAD = 2'd1,
        STATUS_RLE_BAD = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  target;
        logic [7:0]  flags;
        logic [15:0] length;
        logic        sum_ok;
    } frame_info_t;

endpackage

`default_nettype wire

@@ sv/sfd_ram.sv @@
`default_nettype none

module sfd_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 684
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/sfd_parser.sv @@
`default_nettype none

module sfd_parser
    import sfd_pkg::*;
#(
    parameter int BUFFER_BYTES = SFD_BUFFER_BYTES
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             byte_valid,
    input  wire logic [7:0]                       data_byte,
    output logic                                  pay_we,
    output logic      [$clog2(BUFFER_BYTES)-1:0]  pay_waddr,
    output logic      [7:0]                       pay_wdata,
    output logic                                  frame_done,
    output frame_info_t                           info
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int LW = $clog2(BUFFER_BYTES + 1);

    typedef enum logic [8:0] {
        PH_WAIT_A  = 9'b000000001,
        PH_WAIT_B  = 9'b000000010,
        PH_TARGET  = 9'b000000100,
        PH_FLAGS   = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CK_LO   = 9'b010000000,
        PH_CK_HI   = 9'b100000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  target_reg, target_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] len_reg, len_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  ck_lo_reg, ck_lo_next;
    logic        done_reg, done_next;
    logic        sum_ok_reg, sum_ok_next;

    logic [LW-1:0] pos_inc;
    logic [15:0]   len_full;
    logic [15:0]   sum_add;

    assign pos_inc  = pos_reg + LW'(1);
    assign len_full = {data_byte, len_reg[7:0]};
    assign sum_add  = sum_reg + {8'd0, data_byte};

    always_comb
    begin
        phase_next  = phase_reg;
        target_next = target_reg;
        flags_next  = flags_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        ck_lo_next  = ck_lo_reg;
        sum_ok_next = sum_ok_reg;
        done_next   = 1'b0;
        pay_we      = 1'b0;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_WAIT_A:
                begin
                    if (data_byte == HDR_FIRST)
                    begin
                        phase_next = PH_WAIT_B;
                    end
                end
                PH_WAIT_B:
                begin
                    phase_next = (data_byte == HDR_SECOND) ? PH_TARGET : PH_WAIT_A;
                end
                PH_TARGET:
                begin
                    target_next = data_byte;
                    sum_next    = {8'd0, data_byte};
                    phase_next  = PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    flags_next = data_byte;
                    sum_next   = sum_add;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = {8'd0, data_byte};
                    sum_next   = sum_add;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next = len_full;
                    sum_next = sum_add;
                    if (len_full == 16'd0 || len_full > 16'(BUFFER_BYTES))
                    begin
                        phase_next = PH_WAIT_A;
                    end
                    else
                    begin
                        pos_next   = '0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    pay_we   = 1'b1;
                    pos_next = pos_inc;
                    sum_next = sum_add;
                    if (16'(pos_inc) >= len_reg)
                    begin
                        phase_next = PH_CK_LO;
                    end
                end
                PH_CK_LO:
                begin
                    ck_lo_next = data_byte;
                    phase_next = PH_CK_HI;
                end
                PH_CK_HI:
                begin
                    sum_ok_next = ({data_byte, ck_lo_reg} == sum_reg);
                    done_next   = 1'b1;
                    phase_next  = PH_WAIT_A;
                end
                default:
                begin
                    phase_next = PH_WAIT_A;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT_A;
            target_reg <= '0;
            flags_reg  <= '0;
            len_reg    <= '0;
            pos_reg    <= '0;
            sum_reg    <= '0;
            ck_lo_reg  <= '0;
            done_reg   <= 1'b0;
            sum_ok_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            target_reg <= target_next;
            flags_reg  <= flags_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            ck_lo_reg  <= ck_lo_next;
            done_reg   <= done_next;
            sum_ok_reg <= sum_ok_next;
        end
    end

    assign pay_waddr   = pos_reg[AW-1:0];
    assign pay_wdata   = data_byte;
    assign frame_done  = done_reg;
    assign info.target = target_reg;
    assign info.flags  = flags_reg;
    assign info.length = len_reg;
    assign info.sum_ok = sum_ok_reg;

endmodule

`default_nettype wire

@@ sv/sfd_expand.sv @@
`default_nettype none

module sfd_expand
    import sfd_pkg::*;
#(
    parameter int BUFFER_BYTES = SFD_BUFFER_BYTES
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic [$clog2(BUFFER_BYTES+1)-1:0]    length,
    output logic                                      rd_en,
    output logic      [$clog2(BUFFER_BYTES)-1:0]      rd_addr,
    input  wire logic [7:0]                           rd_data,
    output logic                                      wr_en,
    output logic      [$clog2(BUFFER_BYTES)-1:0]      wr_addr,
    output logic      [7:0]                           wr_data,
    output logic                                      done,
    output logic                                      ok
);

    localparam int AW  = $clog2(BUFFER_BYTES);
    localparam int LW  = $clog2(BUFFER_BYTES + 1);
    localparam int AXW = LW + 2;

    typedef enum logic [3:0] {
        EX_IDLE  = 4'b0001,
        EX_CHECK = 4'b0010,
        EX_LOAD  = 4'b0100,
        EX_RUN   = 4'b1000
    } ex_state_t;

    ex_state_t     state_reg, state_next;
    logic [LW-1:0] src_reg, src_next;
    logic [LW-1:0] dst_reg, dst_next;
    logic [LW-1:0] len_reg, len_next;
    logic [2:0]    step_reg, step_next;
    logic [1:0]    comp_reg, comp_next;
    logic [7:0]    run_reg, run_next;
    logic [7:0]    grp_reg [4];
    logic [7:0]    grp_next [4];
    logic          done_reg, done_next;
    logic          ok_reg, ok_next;

    // shared adder for source, destination and bound checks
    logic [AXW-1:0] add_a;
    logic [2:0]     add_b;
    logic [AXW-1:0] add_y;

    assign add_y = add_a + AXW'(add_b);

    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        len_next   = len_reg;
        step_next  = step_reg;
        comp_next  = comp_reg;
        run_next   = run_reg;
        grp_next   = grp_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        add_a      = AXW'(src_reg);
        add_b      = 3'd3;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        unique case (state_reg)
            EX_IDLE:
            begin
                if (start)
                begin
                    src_next   = '0;
                    dst_next   = '0;
                    len_next   = length;
                    state_next = EX_CHECK;
                end
            end
            EX_CHECK:
            begin
                if (add_y < AXW'(len_reg))
                begin
                    step_next  = 3'd0;
                    state_next = EX_LOAD;
                end
                else
                begin
                    done_next  = 1'b1;
                    ok_next    = (dst_reg == LW'(BUFFER_BYTES));
                    state_next = EX_IDLE;
                end
            end
            EX_LOAD:
            begin
                add_b = step_reg;
                if (step_reg != 3'd4)
                begin
                    rd_en = 1'b1;
                end
                if (step_reg != 3'd0)
                begin
                    grp_next[2'(step_reg[1:0] - 2'd1)] = rd_data;
                end
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    src_next   = add_y[LW-1:0];
                    run_next   = grp_reg[0];
                    comp_next  = 2'd0;
                    state_next = EX_RUN;
                end
            end
            EX_RUN:
            begin
                add_a = AXW'(dst_reg);
                if (run_reg == 8'd0)
                begin
                    state_next = EX_CHECK;
                end
                else if (comp_reg == 2'd0)
                begin
                    if (add_y > AXW'(BUFFER_BYTES))
                    begin
                        done_next  = 1'b1;
                        ok_next    = 1'b0;
                        state_next = EX_IDLE;
                    end
                    else
                    begin
                        comp_next = 2'd1;
                    end
                end
                else
                begin
                    add_b    = 3'd1;
                    wr_en    = 1'b1;
                    dst_next = add_y[LW-1:0];
                    if (comp_reg == 2'd3)
                    begin
                        comp_next = 2'd0;
                        run_next  = run_reg - 8'd1;
                    end
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = EX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EX_IDLE;
            src_reg   <= '0;
            dst_reg   <= '0;
            len_reg   <= '0;
            step_reg  <= '0;
            comp_reg  <= '0;
            run_reg   <= '0;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            len_reg   <= len_next;
            step_reg  <= step_next;
            comp_reg  <= comp_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    assign rd_addr = add_y[AW-1:0];
    assign wr_addr = dst_reg[AW-1:0];
    assign wr_data = grp_reg[comp_reg];
    assign done    = done_reg;
    assign ok      = ok_reg;

endmodule

`default_nettype wire

@@ sv/serial_frame_deframer_rle.sv @@
// Serial frame deframer with additive checksum and run-length RGB expansion.
// Input channel (in_valid / in_stall): command 0 feeds one received serial byte,
// command 1 reads one byte (read_index) from the buffer chosen by the last good frame.
// Output channel (out_valid / out_stall): kind 0 is a frame verdict, given once
// per frame that reaches its checksum; kind 1 is a read reply.
// A serial byte that does not finish a frame gives no item.
// A read reply goes through the memory read register and then the output register.
// A raw frame or a checksum mismatch gives its verdict through the parser's done
// register, the check state and the output register. A run-length frame runs the
// expander, one shared adder under a small sequencer that, per run,R,G,B group,
// checks the bound, loads the group, then checks room and writes each pixel's bytes.
// in_stall is high while a read, a verdict or an expansion is in progress.
// When the receiver stalls, the result holds in the output register and no new
// item is taken until it leaves. Reset clears the parser, the good-frame counter
// and the output valid flag; the frame buffers are not cleared and need no pass.
`default_nettype none

module serial_frame_deframer_rle
    import sfd_pkg::*;
#(
    parameter int BUFFER_BYTES = SFD_BUFFER_BYTES
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             command,
    input  wire logic [7:0]       data_byte,
    input  wire logic [IDX_W-1:0] read_index,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  kind,
    output logic      [1:0]       status,
    output logic      [7:0]       target,
    output logic      [7:0]       frame_flags,
    output logic      [LEN_W-1:0] send_length,
    output logic      [7:0]       frame_number,
    output logic      [7:0]       read_data
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int LW = $clog2(BUFFER_BYTES + 1);
    localparam int XW = (LW > IDX_W) ? LW : IDX_W;
    localparam logic [XW-1:0] BUF_X = XW'(BUFFER_BYTES);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_READ   = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_EXPAND = 5'b01000,
        ST_EMIT   = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic [7:0]  count_reg, count_next;
    logic        coded_reg, coded_next;
    logic        idx_ok_reg;
    logic        exp_ok_reg;

    logic              out_valid_reg;
    logic              kind_reg;
    status_t           status_reg;
    logic [7:0]        target_reg;
    logic [7:0]        flags_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [7:0]        number_reg;
    logic [7:0]        rdata_reg;

    logic              load_out;
    logic              o_kind;
    status_t           o_status;
    logic [7:0]        o_target;
    logic [7:0]        o_flags;
    logic [LEN_W-1:0]  o_length;
    logic [7:0]        o_number;
    logic [7:0]        o_rdata;

    logic          accept;
    logic          byte_accept;
    logic          read_accept;
    logic          out_free;
    logic [XW-1:0] idx_ext;
    logic [AW-1:0] idx_addr;

    logic          pay_we;
    logic [AW-1:0] pay_waddr;
    logic [7:0]    pay_wdata;
    logic          pay_re;
    logic [AW-1:0] pay_raddr;
    logic [7:0]    pay_rdata;
    logic [7:0]    exp_rdata;

    logic          frame_done;
    frame_info_t   info;

    logic          exp_start;
    logic          exp_rd_en;
    logic [AW-1:0] exp_rd_addr;
    logic          exp_wr_en;
    logic [AW-1:0] exp_wr_addr;
    logic [7:0]    exp_wr_data;
    logic          exp_done;
    logic          exp_ok;

    assign accept      = in_valid & ~in_stall;
    assign byte_accept = accept & (command == CMD_BYTE);
    assign read_accept = accept & (command == CMD_READ);
    assign out_free    = ~out_valid_reg | ~out_stall;
    assign in_stall    = (state_reg != ST_IDLE) | frame_done | (out_valid_reg & out_stall);
    assign idx_ext     = XW'(read_index);
    assign idx_addr    = idx_ext[AW-1:0];
    assign pay_re      = read_accept | exp_rd_en;
    assign pay_raddr   = (state_reg == ST_EXPAND) ? exp_rd_addr : idx_addr;

    sfd_parser #(.BUFFER_BYTES(BUFFER_BYTES)) u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_accept),
        .data_byte  (data_byte),
        .pay_we     (pay_we),
        .pay_waddr  (pay_waddr),
        .pay_wdata  (pay_wdata),
        .frame_done (frame_done),
        .info       (info)
    );

    sfd_expand #(.BUFFER_BYTES(BUFFER_BYTES)) u_expand
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (exp_start),
        .length  (info.length[LW-1:0]),
        .rd_en   (exp_rd_en),
        .rd_addr (exp_rd_addr),
        .rd_data (pay_rdata),
        .wr_en   (exp_wr_en),
        .wr_addr (exp_wr_addr),
        .wr_data (exp_wr_data),
        .done    (exp_done),
        .ok      (exp_ok)
    );

    sfd_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_payload_ram
    (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .re    (pay_re),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    sfd_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_expanded_ram
    (
        .clk   (clk),
        .we    (exp_wr_en),
        .waddr (exp_wr_addr),
        .wdata (exp_wr_data),
        .re    (read_accept),
        .raddr (idx_addr),
        .rdata (exp_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        coded_next = coded_reg;
        exp_start  = 1'b0;
        load_out   = 1'b0;
        o_kind     = KIND_VERDICT;
        o_status   = STATUS_OK;
        o_target   = info.target;
        o_flags    = info.flags;
        o_length   = '0;
        o_number   = count_reg;
        o_rdata    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_done)
                begin
                    state_next = ST_CHECK;
                end
                else if (read_accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    o_kind     = KIND_READ;
                    o_target   = '0;
                    o_flags    = '0;
                    o_number   = '0;
                    if (idx_ok_reg)
                    begin
                        o_rdata = coded_reg ? exp_rdata : pay_rdata;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (!info.sum_ok)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        o_status   = STATUS_SUM_BAD;
                        state_next = ST_IDLE;
                    end
                end
                else if (info.flags[RLE_FLAG_BIT])
                begin
                    exp_start  = 1'b1;
                    state_next = ST_EXPAND;
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    o_length   = info.length[LEN_W-1:0];
                    count_next = count_reg + 8'd1;
                    coded_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_EXPAND:
            begin
                if (exp_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (exp_ok_reg)
                    begin
                        o_length   = BUF_X[LEN_W-1:0];
                        count_next = count_reg + 8'd1;
                        coded_next = 1'b1;
                    end
                    else
                    begin
                        o_status = STATUS_RLE_BAD;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            coded_reg     <= 1'b0;
            idx_ok_reg    <= 1'b0;
            exp_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            coded_reg <= coded_next;
            if (read_accept)
            begin
                idx_ok_reg <= (idx_ext < BUF_X);
            end
            if (exp_done)
            begin
                exp_ok_reg <= exp_ok;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            kind_reg   <= o_kind;
            status_reg <= o_status;
            target_reg <= o_target;
            flags_reg  <= o_flags;
            length_reg <= o_length;
            number_reg <= o_number;
            rdata_reg  <= o_rdata;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign status       = status_reg;
    assign target       = target_reg;
    assign frame_flags  = flags_reg;
    assign send_length  = length_reg;
    assign frame_number = number_reg;
    assign read_data    = rdata_reg;

endmodule

`default_nettype wire

@@ test/serial_frame_deframer_rle_test.sv @@
module serial_frame_deframer_rle_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sfd_pkg::*;

    localparam int ITEM_GOAL = 1400;
    localparam int RESULT_GOAL = 60;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PIXEL_BYTES = SFD_BUFFER_BYTES / 3;

    typedef enum logic [3:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        GET_TARGET,
        GET_FLAGS,
        GET_LEN_LO,
        GET_LEN_HI,
        GET_PAYLOAD,
        GET_SUM_LO,
        GET_SUM_HI
    } parse_phase_t;

    typedef struct packed {
        logic             kind;
        status_t          status;
        logic [7:0]       target;
        logic [7:0]       frame_flags;
        logic [LEN_W-1:0] send_length;
        logic [7:0]       frame_number;
        logic [7:0]       read_data;
    } deframer_reply_t;

    class deframer_scoreboard;
        parse_phase_t phase;
        logic [7:0] held_target;
        logic [7:0] held_flags;
        logic [15:0] frame_length;
        int payload_count;
        logic [15:0] sum_running;
        logic [15:0] sum_received;
        logic [7:0] good_frames;
        logic [7:0] payload_mem [SFD_BUFFER_BYTES];
        logic [7:0] pixel_mem [SFD_BUFFER_BYTES];
        bit payload_seen [SFD_BUFFER_BYTES];
        bit pixel_seen [SFD_BUFFER_BYTES];
        bit last_coded;
        deframer_reply_t expected_replies [$];
        int replies_predicted;
        int mismatches;
        int n_ok;
        int n_sum_bad;
        int n_rle_bad;
        int n_reads;

        function new();
            phase = SEEK_FIRST;
            held_target = 8'h00;
            held_flags = 8'h00;
            frame_length = 16'h0000;
            payload_count = 0;
            sum_running = 16'h0000;
            sum_received = 16'h0000;
            good_frames = 8'h00;
            last_coded = 1'b0;
            replies_predicted = 0;
            mismatches = 0;
            n_ok = 0;
            n_sum_bad = 0;
            n_rle_bad = 0;
            n_reads = 0;
        endfunction

        function bit readable(int idx);
            if (idx >= SFD_BUFFER_BYTES)
                return 1'b1;
            return last_coded ? pixel_seen[idx] : payload_seen[idx];
        endfunction

        function bit expand_pixels();
            int src;
            int dst;
            int run;
            int i;
            src = 0;
            dst = 0;
            while (src + 3 < frame_length) begin
                run = payload_mem[src];
                for (i = 0; i < run; i++) begin
                    if (dst + 3 > SFD_BUFFER_BYTES)
                        return 1'b0;
                    pixel_mem[dst] = payload_mem[src + 1];
                    pixel_mem[dst + 1] = payload_mem[src + 2];
                    pixel_mem[dst + 2] = payload_mem[src + 3];
                    pixel_seen[dst] = 1'b1;
                    pixel_seen[dst + 1] = 1'b1;
                    pixel_seen[dst + 2] = 1'b1;
                    dst += 3;
                end
                src += 4;
            end
            return dst == SFD_BUFFER_BYTES;
        endfunction

        function void close_frame();
            deframer_reply_t r;
            r = '0;
            r.kind = KIND_VERDICT;
            r.target = held_target;
            r.frame_flags = held_flags;
            r.frame_number = good_frames;
            if (sum_received != sum_running)
                r.status = STATUS_SUM_BAD;
            else if (held_flags[RLE_FLAG_BIT] && !expand_pixels())
                r.status = STATUS_RLE_BAD;
            else
            begin
                r.status = STATUS_OK;
                r.send_length = held_flags[RLE_FLAG_BIT] ? LEN_W'(SFD_BUFFER_BYTES)
                                                         : frame_length[LEN_W-1:0];
                last_coded = held_flags[RLE_FLAG_BIT];
                good_frames = good_frames + 8'd1;
            end
            expected_replies.push_back(r);
            replies_predicted++;
        endfunction

        function void note_accepted(logic cmd, logic [7:0] b, logic [IDX_W-1:0] idx);
            deframer_reply_t r;
            if (cmd == CMD_READ)
            begin
                r = '0;
                r.kind = KIND_READ;
                if (idx < SFD_BUFFER_BYTES)
                    r.read_data = last_coded ? pixel_mem[idx] : payload_mem[idx];
                expected_replies.push_back(r);
                replies_predicted++;
                return;
            end
            case (phase)
                SEEK_FIRST:
                    if (b == HDR_FIRST)
                        phase = SEEK_SECOND;
                SEEK_SECOND:
                    phase = (b == HDR_SECOND) ? GET_TARGET : SEEK_FIRST;
                GET_TARGET:
                begin
                    held_target = b;
                    sum_running = 16'(b);
                    phase = GET_FLAGS;
                end
                GET_FLAGS:
                begin
                    held_flags = b;
                    sum_running = sum_running + 16'(b);
                    phase = GET_LEN_LO;
                end
                GET_LEN_LO:
                begin
                    frame_length = 16'(b);
                    sum_running = sum_running + 16'(b);
                    phase = GET_LEN_HI;
                end
                GET_LEN_HI:
                begin
                    frame_length[15:8] = b;
                    sum_running = sum_running + 16'(b);
                    if (frame_length == 16'h0000 || frame_length > SFD_BUFFER_BYTES)
                        phase = SEEK_FIRST;
                    else
                    begin
                        payload_count = 0;
                        phase = GET_PAYLOAD;
                    end
                end
                GET_PAYLOAD:
                begin
                    payload_mem[payload_count] = b;
                    payload_seen[payload_count] = 1'b1;
                    payload_count++;
                    sum_running = sum_running + 16'(b);
                    if (payload_count >= frame_length)
                        phase = GET_SUM_LO;
                end
                GET_SUM_LO:
                begin
                    sum_received = 16'(b);
                    phase = GET_SUM_HI;
                end
                GET_SUM_HI:
                begin
                    sum_received[15:8] = b;
                    phase = SEEK_FIRST;
                    close_frame();
                end
                default:
                    phase = SEEK_FIRST;
            endcase
        endfunction

        function void check_reply(deframer_reply_t got);
            deframer_reply_t want;
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item out: kind %0d status %0d target %02h data %02h",
                             got.kind, got.status, got.target, got.read_data);
                return;
            end
            want = expected_replies.pop_front();
            if (want.kind == KIND_READ)
                n_reads++;
            else if (want.status == STATUS_OK)
                n_ok++;
            else if (want.status == STATUS_SUM_BAD)
                n_sum_bad++;
            else
                n_rle_bad++;
            if (got.kind !== want.kind || got.status !== want.status
                || got.target !== want.target || got.frame_flags !== want.frame_flags
                || got.send_length !== want.send_length
                || got.frame_number !== want.frame_number
                || got.read_data !== want.read_data)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch (exp/got): kind %0d/%0d status %0d/%0d target %02h/%02h",
                             want.kind, got.kind, want.status, got.status,
                             want.target, got.target);
                    $display("  flags %02h/%02h length %0d/%0d number %0d/%0d data %02h/%02h",
                             want.frame_flags, got.frame_flags, want.send_length,
                             got.send_length, want.frame_number, got.frame_number,
                             want.read_data, got.read_data);
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             command;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] read_index;
    logic             out_valid;
    logic             out_stall;
    logic             kind;
    logic [1:0]       status;
    logic [7:0]       target;
    logic [7:0]       frame_flags;
    logic [LEN_W-1:0] send_length;
    logic [7:0]       frame_number;
    logic [7:0]       read_data;

    deframer_scoreboard board = new();
    int items_sent;
    int cycle_count;
    bit feed_calm;

    serial_frame_deframer_rle dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .data_byte    (data_byte),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .status       (status),
        .target       (target),
        .frame_flags  (frame_flags),
        .send_length  (send_length),
        .frame_number (frame_number),
        .read_data    (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic int wait_cycles(bit calm);
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(1, 13);
    endfunction

    task automatic push_item(input logic cmd, input logic [7:0] b, input logic [IDX_W-1:0] idx);
        int gap;
        gap = wait_cycles(feed_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        data_byte <= b;
        read_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        board.note_accepted(cmd, b, idx);
        items_sent++;
        if ($urandom_range(0, 59) == 0)
            feed_calm = !feed_calm;
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_item(CMD_BYTE, b, IDX_W'($urandom_range(0, 1023)));
    endtask

    // in-range reads only hit entries the selected buffer already holds
    task automatic send_read();
        int idx;
        int tries;
        idx = -1;
        if ($urandom_range(0, 3) != 0)
        begin
            for (tries = 0; tries < 8 && idx < 0; tries++)
            begin
                case ($urandom_range(0, 9))
                    0: idx = 0;
                    1: idx = SFD_BUFFER_BYTES - 1;
                    default: idx = $urandom_range(0, SFD_BUFFER_BYTES - 1);
                endcase
                if (!board.readable(idx))
                    idx = -1;
            end
        end
        if (idx < 0)
            idx = $urandom_range(SFD_BUFFER_BYTES, 1023);
        push_item(CMD_READ, 8'($urandom), IDX_W'(idx));
    endtask

    task automatic send_frame(input logic [7:0] tgt, input logic [7:0] flags,
                              input logic [15:0] len, input logic [7:0] body [$],
                              input bit spoil, input bit cut, input int read_pct);
        logic [7:0] octets [$];
        logic [15:0] csum;
        csum = 16'(tgt) + 16'(flags) + 16'(len[7:0]) + 16'(len[15:8]);
        foreach (body[k])
            csum = csum + 16'(body[k]);
        if (spoil)
            csum = csum ^ 16'($urandom_range(1, 65535));
        octets.push_back(HDR_FIRST);
        octets.push_back(HDR_SECOND);
        octets.push_back(tgt);
        octets.push_back(flags);
        octets.push_back(len[7:0]);
        octets.push_back(len[15:8]);
        if (len != 16'h0000 && len <= SFD_BUFFER_BYTES)
        begin
            foreach (body[k])
                octets.push_back(body[k]);
            if (!cut)
            begin
                octets.push_back(csum[7:0]);
                octets.push_back(csum[15:8]);
            end
        end
        foreach (octets[k])
        begin
            send_byte(octets[k]);
            if ($urandom_range(0, 99) < read_pct)
                send_read();
        end
    endtask

    task automatic settle_parser();
        logic [7:0] b;
        while (board.phase != SEEK_FIRST)
        begin
            b = 8'($urandom);
            send_byte((b == HDR_FIRST || b == HDR_SECOND) ? 8'h00 : b);
        end
    endtask

    // result side
    initial
    begin
        int hold;
        bit drain_calm;
        deframer_reply_t got;
        hold = 0;
        drain_calm = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.kind = kind;
                got.status = status_t'(status);
                got.target = target;
                got.frame_flags = frame_flags;
                got.send_length = send_length;
                got.frame_number = frame_number;
                got.read_data = read_data;
                board.check_reply(got);
                hold = wait_cycles(drain_calm);
                if ($urandom_range(0, 29) == 0)
                    drain_calm = !drain_calm;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        logic [7:0] body [$];
        logic [7:0] tgt;
        logic [7:0] b;
        logic [15:0] len;
        int pick;
        int groups;
        int pixels;
        int left;
        int run;
        int g;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        command <= CMD_BYTE;
        data_byte <= 8'h00;
        read_index <= '0;
        items_sent = 0;
        feed_calm = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // out-of-range reads before any frame
        push_item(CMD_READ, 8'h00, IDX_W'(1023));
        push_item(CMD_READ, 8'hFF, IDX_W'(SFD_BUFFER_BYTES));
        // a repeated first header byte is not a fresh start
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        body = '{8'hFF};
        send_frame(8'h00, 8'hFE, 16'd1, body, 1'b0, 1'b0, 0);
        push_item(CMD_READ, 8'h00, IDX_W'(0));
        body.delete();
        send_frame(8'hFF, 8'h01, 16'h0000, body, 1'b0, 1'b0, 0);
        send_frame(8'hFF, 8'hFF, 16'hFFFF, body, 1'b0, 1'b0, 0);

        // one full-size raw frame makes the whole payload buffer readable
        repeat (SFD_BUFFER_BYTES) body.push_back(8'($urandom));
        send_frame(8'($urandom), 8'($urandom) & 8'hFE, 16'(SFD_BUFFER_BYTES), body,
                   1'b0, 1'b0, 0);

        while (items_sent < ITEM_GOAL || board.replies_predicted < RESULT_GOAL)
        begin
            pick = $urandom_range(0, 99);
            tgt = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
            body.delete();
            if (pick < 35)
            begin
                len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(21, 120))
                                                  : 16'($urandom_range(1, 20));
                repeat (len) body.push_back(8'($urandom));
                send_frame(tgt, 8'($urandom) & 8'hFE, len, body,
                           $urandom_range(0, 6) == 0, 1'b0, 8);
            end
            else if (pick < 65)
            begin
                groups = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 6);
                case ($urandom_range(0, 9))
                    6: pixels = $urandom_range(PIXEL_BYTES - 100, PIXEL_BYTES - 1);
                    7: pixels = $urandom_range(PIXEL_BYTES + 1, 300);
                    8: pixels = 0;
                    default: pixels = PIXEL_BYTES;
                endcase
                left = pixels;
                for (g = 0; g < groups; g++)
                begin
                    if (g == groups - 1)
                        run = (left > 255) ? 255 : left;
                    else if (left == 0 || $urandom_range(0, 4) == 0)
                        run = 0;
                    else
                        run = $urandom_range(1, (left > 255) ? 255 : left);
                    left -= run;
                    body.push_back(8'(run));
                    repeat (3) body.push_back(8'($urandom));
                end
                // trailing bytes short of a group
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
                send_frame(tgt, 8'($urandom) | 8'h01, 16'(body.size()), body,
                           $urandom_range(0, 9) == 0, 1'b0, 8);
            end
            else if (pick < 75)
                repeat ($urandom_range(1, 4)) send_read();
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    b = ($urandom_range(0, 2) == 0) ? HDR_FIRST : 8'($urandom);
                    send_byte((b == HDR_SECOND) ? 8'h54 : b);
                end
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        send_byte(HDR_FIRST);
                        b = 8'($urandom);
                        send_byte((b == HDR_SECOND) ? HDR_FIRST : b);
                    end
                    1:
                    begin
                        case ($urandom_range(0, 2))
                            0: len = 16'h0000;
                            1: len = 16'(SFD_BUFFER_BYTES + 1);
                            default: len = 16'($urandom_range(SFD_BUFFER_BYTES + 1, 65535));
                        endcase
                        send_frame(tgt, 8'($urandom), len, body, 1'b0, 1'b0, 0);
                    end
                    default:
                    begin
                        len = 16'($urandom_range(4, 20));
                        repeat ($urandom_range(0, len - 1)) body.push_back(8'($urandom));
                        send_frame(tgt, 8'($urandom), len, body, 1'b0, 1'b1, 0);
                    end
                endcase
            end
            settle_parser();
        end
        in_valid <= 1'b0;

        while (board.expected_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("fed %0d items: %0d good frames, %0d checksum mismatches, %0d failed expansions",
                 items_sent, board.n_ok, board.n_sum_bad, board.n_rle_bad);
        $display("%0d read replies checked, %0d mismatches, %0d cycles",
                 board.n_reads, board.mismatches, cycle_count);
        if (board.mismatches == 0 && board.expected_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/sfd_pkg.sv
sv/sfd_ram.sv
sv/sfd_parser.sv
sv/sfd_expand.sv
sv/serial_frame_deframer_rle.sv
test/serial_frame_deframer_rle_test.sv
